// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define LSF_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define LSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lsf_pkg
// Shared codes and types of the learning switch forwarder.
// ----------------------------------------------------------------------------
package lsf_pkg;

    localparam logic [1:0] REQ_DATA  = 2'd0;
    localparam logic [1:0] REQ_STATE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    localparam logic KIND_FWD    = 1'b0;
    localparam logic KIND_BEACON = 1'b1;

    localparam logic [1:0] CFG_NUM_PORTS = 2'd0;
    localparam logic [1:0] CFG_OWN_ID    = 2'd1;
    localparam logic [1:0] CFG_BCAST     = 2'd2;

    localparam logic [3:0]  NUM_PORTS_RST = 4'd8;
    localparam logic [15:0] FLOOD_DEFAULT = 16'd1000;
    localparam logic [2:0]  BEACON_PERIOD = 3'd5;

    typedef struct packed {
        logic [1:0] req;
        logic       look;
    } t_qhdr;

endpackage

// ===== rtl/core/learning_switch_forwarder.sv =====
// ----------------------------------------------------------------------------
// learning_switch_forwarder
// Data beat: result follows a scan of the ports in use (one table compare
// per cycle); state and tick beats complete without a scan.
// Synchronous reset clears the table, root, beacon count and config at once.
// ----------------------------------------------------------------------------
module learning_switch_forwarder
    import lsf_pkg::*;
#(
    parameter int MAX_PORTS = 8,
    parameter int ADDR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_req_type,
    input  logic [2:0]  i_in_port,
    input  logic [15:0] i_src_addr,
    input  logic [15:0] i_dst_addr,
    input  logic [7:0]  i_rx_root,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_out_kind,
    output logic [7:0]  o_port_mask,
    output logic [7:0]  o_beacon_root
);

    localparam int PW = $clog2(MAX_PORTS);
    localparam int NW = $clog2(MAX_PORTS + 1);

    logic [3:0]           r_num_ports;
    logic [15:0]          r_bcast;
    logic [NW-1:0]        eff_ports;
    logic                 cfg_we;
    logic                 root_load;
    logic                 q_valid;
    logic                 q_pop;
    t_qhdr                q_hdr;
    logic [PW-1:0]        q_port;
    logic [ADDR_BITS-1:0] q_src;
    logic [ADDR_BITS-1:0] q_dst;
    logic [7:0]           q_root;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign root_load   = cfg_we && (i_cfg_index == CFG_OWN_ID);
    assign eff_ports   = (int'(r_num_ports) > MAX_PORTS) ? NW'(MAX_PORTS) : NW'(r_num_ports);

    // own_id lives in the back end's root register, loaded on its write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_ports <= NUM_PORTS_RST;
            r_bcast     <= FLOOD_DEFAULT;
        end else if (cfg_we) begin
            unique case (i_cfg_index)
                CFG_NUM_PORTS: r_num_ports <= i_cfg_data[3:0];
                CFG_BCAST:     r_bcast     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lsf_front #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_req_type    (i_req_type),
        .i_in_port     (i_in_port),
        .i_src_addr    (i_src_addr),
        .i_dst_addr    (i_dst_addr),
        .i_rx_root     (i_rx_root),
        .i_n_ports     (eff_ports),
        .i_bcast_below (r_bcast),
        .o_q_valid     (q_valid),
        .i_q_pop       (q_pop),
        .o_q_hdr       (q_hdr),
        .o_q_port      (q_port),
        .o_q_src       (q_src),
        .o_q_dst       (q_dst),
        .o_q_root      (q_root)
    );

    lsf_back #(
        .MAX_PORTS (MAX_PORTS),
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_n_ports     (eff_ports),
        .i_root_load   (root_load),
        .i_own_id      (i_cfg_data[7:0]),
        .i_q_valid     (q_valid),
        .o_q_pop       (q_pop),
        .i_q_hdr       (q_hdr),
        .i_q_port      (q_port),
        .i_q_src       (q_src),
        .i_q_dst       (q_dst),
        .i_q_root      (q_root),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_kind    (o_out_kind),
        .o_port_mask   (o_port_mask),
        .o_beacon_root (o_beacon_root)
    );

endmodule

// ===== rtl/core/lsf_front.sv =====
// ----------------------------------------------------------------------------
// lsf_front
// Accepts request beats, drops ones that do nothing, queues the rest.
// ----------------------------------------------------------------------------
module lsf_front
    import lsf_pkg::*;
#(
    parameter int MAX_PORTS = 8,
    parameter int ADDR_BITS = 16,
    parameter int PW        = $clog2(MAX_PORTS),
    parameter int NW        = $clog2(MAX_PORTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [1:0]           i_req_type,
    input  logic [2:0]           i_in_port,
    input  logic [15:0]          i_src_addr,
    input  logic [15:0]          i_dst_addr,
    input  logic [7:0]           i_rx_root,
    input  logic [NW-1:0]        i_n_ports,
    input  logic [15:0]          i_bcast_below,
    output logic                 o_q_valid,
    input  logic                 i_q_pop,
    output t_qhdr                o_q_hdr,
    output logic [PW-1:0]        o_q_port,
    output logic [ADDR_BITS-1:0] o_q_src,
    output logic [ADDR_BITS-1:0] o_q_dst,
    output logic [7:0]           o_q_root
);

    localparam int QD = 2;

    t_qhdr                r_hdr  [QD];
    logic [PW-1:0]        r_port [QD];
    logic [ADDR_BITS-1:0] r_src  [QD];
    logic [ADDR_BITS-1:0] r_dst  [QD];
    logic [7:0]           r_root [QD];
    logic                 r_wr, n_wr;
    logic                 r_rd, n_rd;
    logic [1:0]           r_count, n_count;

    logic [ADDR_BITS-1:0] dst_m;
    logic                 keep;
    logic                 push;
    logic                 pop;
    t_qhdr                hdr;

    assign dst_m      = ADDR_BITS'(i_dst_addr);
    assign o_in_stall = (r_count == 2'd2);

    always_comb begin
        keep = 1'b0;
        unique case (i_req_type)
            REQ_DATA:  keep = (32'(i_in_port) < 32'(i_n_ports));
            REQ_STATE: keep = 1'b1;
            REQ_TICK:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
        hdr.req  = i_req_type;
        hdr.look = (32'(dst_m) >= 32'(i_bcast_below));
    end

    assign push = i_in_valid && !o_in_stall && keep;
    assign pop  = i_q_pop && o_q_valid;

    always_comb begin
        n_wr    = push ? ~r_wr : r_wr;
        n_rd    = pop  ? ~r_rd : r_rd;
        n_count = r_count + 2'(push) - 2'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_hdr[r_wr]  <= hdr;
            r_port[r_wr] <= PW'(i_in_port);
            r_src[r_wr]  <= ADDR_BITS'(i_src_addr);
            r_dst[r_wr]  <= dst_m;
            r_root[r_wr] <= i_rx_root;
        end
    end

    assign o_q_valid = (r_count != 2'd0);
    assign o_q_hdr   = r_hdr[r_rd];
    assign o_q_port  = r_port[r_rd];
    assign o_q_src   = r_src[r_rd];
    assign o_q_dst   = r_dst[r_rd];
    assign o_q_root  = r_root[r_rd];

endmodule

// ===== rtl/core/lsf_back.sv =====
// ----------------------------------------------------------------------------
// lsf_back
// Learns, scans the address table one port per cycle, tracks root and
// beacon timing, and holds the result beat.
// ----------------------------------------------------------------------------
module lsf_back
    import lsf_pkg::*;
#(
    parameter int MAX_PORTS = 8,
    parameter int ADDR_BITS = 16,
    parameter int PW        = $clog2(MAX_PORTS),
    parameter int NW        = $clog2(MAX_PORTS + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [NW-1:0]        i_n_ports,
    input  logic                 i_root_load,
    input  logic [7:0]           i_own_id,
    input  logic                 i_q_valid,
    output logic                 o_q_pop,
    input  t_qhdr                i_q_hdr,
    input  logic [PW-1:0]        i_q_port,
    input  logic [ADDR_BITS-1:0] i_q_src,
    input  logic [ADDR_BITS-1:0] i_q_dst,
    input  logic [7:0]           i_q_root,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_out_kind,
    output logic [7:0]           o_port_mask,
    output logic [7:0]           o_beacon_root
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    logic [PW-1:0]        r_idx, n_idx;
    logic [PW-1:0]        r_port, n_port;
    logic [ADDR_BITS-1:0] r_dst, n_dst;
    logic                 r_look, n_look;
    logic [ADDR_BITS-1:0] r_table [MAX_PORTS];
    logic [NW-1:0]        r_last, n_last;
    logic [7:0]           r_root, n_root;
    logic [2:0]           r_bcnt, n_bcnt;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_kind, n_out_kind;
    logic [7:0]           r_out_mask, n_out_mask;
    logic [7:0]           r_out_root, n_out_root;

    logic                 tbl_we;
    logic                 hit;
    logic                 last;
    logic [MAX_PORTS-1:0] one;

    function automatic logic [MAX_PORTS-1:0] flood(logic [NW-1:0] n, logic [NW-1:0] ex);
        logic [MAX_PORTS-1:0] m;
        m = '0;
        for (int i = 0; i < MAX_PORTS; i++) begin
            m[i] = (i < int'(n)) && (i != int'(ex));
        end
        return m;
    endfunction

    assign one     = MAX_PORTS'(1);
    assign o_q_pop = (r_state == S_IDLE) && i_q_valid && (!r_out_valid || !i_out_stall);
    assign hit     = r_look && (r_table[r_idx] == r_dst);
    assign last    = (int'(r_idx) + 1 >= int'(i_n_ports));

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_port      = r_port;
        n_dst       = r_dst;
        n_look      = r_look;
        n_last      = r_last;
        n_root      = r_root;
        n_bcnt      = r_bcnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_kind  = r_out_kind;
        n_out_mask  = r_out_mask;
        n_out_root  = r_out_root;
        tbl_we      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (o_q_pop) begin
                    unique case (i_q_hdr.req)
                        REQ_DATA: begin
                            tbl_we  = 1'b1;
                            n_last  = NW'(i_q_port);
                            n_port  = i_q_port;
                            n_dst   = i_q_dst;
                            n_look  = i_q_hdr.look;
                            n_idx   = '0;
                            n_state = S_SCAN;
                        end
                        REQ_STATE: begin
                            if (i_q_root < r_root) begin
                                n_root = i_q_root;
                            end
                        end
                        REQ_TICK: begin
                            if (r_bcnt == BEACON_PERIOD) begin
                                n_bcnt      = 3'd1;
                                n_out_valid = 1'b1;
                                n_out_kind  = KIND_BEACON;
                                n_out_mask  = 8'(flood(i_n_ports, r_last));
                                n_out_root  = r_root;
                            end else begin
                                n_bcnt = r_bcnt + 3'd1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_FWD;
                    n_out_mask  = 8'(one << r_idx);
                    n_out_root  = 8'd0;
                    n_state     = S_IDLE;
                end else if (!r_look || last) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_FWD;
                    n_out_mask  = 8'(flood(i_n_ports, NW'(r_port)));
                    n_out_root  = 8'd0;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = r_idx + PW'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_root_load) begin
            n_root = i_own_id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= NW'(MAX_PORTS);
            r_root      <= 8'd0;
            r_bcnt      <= 3'd0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < MAX_PORTS; i++) begin
                r_table[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_root      <= n_root;
            r_bcnt      <= n_bcnt;
            r_out_valid <= n_out_valid;
            if (tbl_we) begin
                r_table[i_q_port] <= i_q_src;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_port     <= n_port;
        r_dst      <= n_dst;
        r_look     <= n_look;
        r_out_kind <= n_out_kind;
        r_out_mask <= n_out_mask;
        r_out_root <= n_out_root;
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_kind    = r_out_kind;
    assign o_port_mask   = r_out_mask;
    assign o_beacon_root = r_out_root;

endmodule

// ===== rtl/core/lsf_checker.sv =====
// ----------------------------------------------------------------------------
// lsf_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lsf_checker
    import lsf_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [1:0]  i_cfg_index,
    input logic [15:0] i_cfg_data,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_out_kind,
    input logic [7:0]  o_port_mask,
    input logic [7:0]  o_beacon_root
);

    logic [3:0] r_np;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_np <= NUM_PORTS_RST;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index == CFG_NUM_PORTS)) begin
            r_np <= i_cfg_data[3:0];
        end
    end

    `LSF_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_kind) && $stable(o_port_mask) && $stable(o_beacon_root), "result beat changed under stall")
    `LSF_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_out_valid, "result beat after reset")
    `LSF_ASSERT(a_fwd_root, i_clk, i_rst_n, o_out_valid && (o_out_kind == KIND_FWD) |-> o_beacon_root == 8'd0, "forward beat carries a root")
    `LSF_ASSERT(a_mask, i_clk, i_rst_n, o_out_valid |-> (16'(o_port_mask) >> r_np) == 16'd0, "mask names a port not in use")

endmodule

bind learning_switch_forwarder lsf_checker u_lsf_checker (.*);
